// ===== rtl/core/shape_pair_overlap_test_macros.svh =====
// assertion macros shared by the core modules
// every use sits inside a module that has clk and rst_n
`ifndef SHAPE_PAIR_OVERLAP_TEST_MACROS_SVH
`define SHAPE_PAIR_OVERLAP_TEST_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SPO_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spo assertion failed");
`define SPO_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spo assertion failed");
`else
`define SPO_ASSERT_SAME(lbl, ante, cons)
`define SPO_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/spo_pkg.sv =====
`default_nettype none
package spo_pkg;

    localparam int COORD_BITS   = 24;
    localparam int SIZE_BITS    = COORD_BITS - 1;
    // a gap along one axis stays below 2**COORD_BITS
    localparam int MAG_BITS     = COORD_BITS;
    localparam int RAD_BITS     = COORD_BITS;
    localparam int SQ_BITS      = 2 * MAG_BITS;
    localparam int RSQ_BITS     = 2 * RAD_BITS;
    localparam int DIST_BITS    = SQ_BITS + 1;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int PAIR_EN_BITS = 4;

    localparam logic [PAIR_EN_BITS-1:0] PAIR_EN_RESET = 4'hF;

    localparam logic [1:0] KIND_BOX    = 2'd0;
    localparam logic [1:0] KIND_CIRCLE = 2'd1;

    // pair enable bit positions, indexed by {a is circle, b is circle}
    localparam logic [1:0] EN_BOX_BOX       = 2'd0;
    localparam logic [1:0] EN_BOX_CIRCLE    = 2'd1;
    localparam logic [1:0] EN_CIRCLE_BOX    = 2'd2;
    localparam logic [1:0] EN_CIRCLE_CIRCLE = 2'd3;

    localparam logic STATUS_TESTED      = 1'b0;
    localparam logic STATUS_UNSUPPORTED = 1'b1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [SIZE_BITS-1:0]         dim_t;

    typedef struct packed {
        logic [1:0] a_kind;
        coord_t     a_x;
        coord_t     a_y;
        dim_t       a_size_one;
        dim_t       a_size_two;
        logic [1:0] b_kind;
        coord_t     b_x;
        coord_t     b_y;
        dim_t       b_size_one;
        dim_t       b_size_two;
    } pair_in_t;

    typedef struct packed {
        logic hit;
        logic status;
    } pair_out_t;

    typedef enum logic [2:0] {
        PAIR_NONE,
        PAIR_BB,
        PAIR_BC,
        PAIR_CB,
        PAIR_CC
    } pair_mode_t;

    typedef enum logic [1:0] {
        JOB_SKIP,
        JOB_BOX,
        JOB_ROUND
    } job_kind_t;

    typedef struct packed {
        job_kind_t            kind;
        logic                 box_hit;
        logic [MAG_BITS-1:0]  dist_x;
        logic [MAG_BITS-1:0]  dist_y;
        logic [RAD_BITS-1:0]  rad;
    } job_t;

endpackage
`default_nettype wire

// ===== rtl/core/shape_pair_overlap_test.sv =====
// shape pair overlap test
// in channel (in_valid, in_ready, in_data): one pair of 2d shapes per transfer,
// each a box (min corner plus width and height) or a circle (centre plus radius)
// out channel (out_valid, out_ready, out_data): one verdict per pair, in order,
// hit set when the shapes overlap, status set when the pair is unsupported
// cfg channel (cfg_valid, cfg_ready, cfg_data): writes the 4 bit pair enable mask,
// bit 0 box-box, bit 1 box-circle, bit 2 circle-box, bit 3 circle-circle;
// cfg_ready is always high, write only while the block is idle
// a transferred pair passes the input register, the four entry queue and the
// squaring stage, then the output register after the compare raises out_valid
// throughput: one pair per cycle while out_ready stays high
// reset: the queue and pipeline empty, pair enable returns to all pairs enabled
// a stalled receiver fills the output register, the squaring stage and the
// queue; in_ready drops only once those and the input register are full
`default_nettype none
module shape_pair_overlap_test
    import spo_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  pair_in_t                in_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output pair_out_t               out_data,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [PAIR_EN_BITS-1:0] cfg_data
);

    logic [PAIR_EN_BITS-1:0] pair_enable_reg;
    logic                    push_valid;
    logic                    push_ready;
    job_t                    push_data;
    logic                    pop_valid;
    logic                    pop_ready;
    job_t                    pop_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_enable_reg <= PAIR_EN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            pair_enable_reg <= cfg_data;
        end
    end

    spo_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .pair_enable (pair_enable_reg),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_data   (push_data)
    );

    spo_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    spo_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

// ===== rtl/core/spo_front.sv =====
`default_nettype none
`include "shape_pair_overlap_test_macros.svh"
module spo_front
    import spo_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  pair_in_t                in_data,
    input  logic [PAIR_EN_BITS-1:0] pair_enable,
    output logic                    push_valid,
    input  logic                    push_ready,
    output job_t                    push_data
);

    typedef logic signed [COORD_BITS:0] ext_coord_t;

    // distance from c to the closed interval [o, o + w], zero inside
    function automatic logic [MAG_BITS-1:0] axis_gap(
        input coord_t c,
        input coord_t o,
        input dim_t   w
    );
        logic signed [COORD_BITS:0]   below;
        logic signed [COORD_BITS+1:0] above;
        logic [MAG_BITS-1:0]          gap;
        below = (COORD_BITS+1)'(o) - (COORD_BITS+1)'(c);
        above = (COORD_BITS+2)'(c) - (COORD_BITS+2)'(o) - $signed({3'b000, w});
        if (!below[COORD_BITS] && (below != '0))
        begin
            gap = below[MAG_BITS-1:0];
        end
        else if (!above[COORD_BITS+1] && (above != '0))
        begin
            gap = above[MAG_BITS-1:0];
        end
        else
        begin
            gap = '0;
        end
        return gap;
    endfunction

    logic       valid_reg;
    pair_in_t   item_reg;
    pair_mode_t mode_reg;
    pair_mode_t mode_next;

    logic       kind_ok;
    logic [1:0] pair_sel;

    logic       swap;
    logic       round;
    coord_t     c_x;
    coord_t     c_y;
    coord_t     o_x;
    coord_t     o_y;
    dim_t       c_r;
    dim_t       o_r;
    dim_t       o_w;
    dim_t       o_h;
    ext_coord_t ax_lo;
    ext_coord_t ay_lo;
    ext_coord_t bx_lo;
    ext_coord_t by_lo;
    ext_coord_t ax_hi;
    ext_coord_t ay_hi;
    ext_coord_t bx_hi;
    ext_coord_t by_hi;

    // classify on the way in
    always_comb
    begin
        kind_ok  = ((in_data.a_kind == KIND_BOX) || (in_data.a_kind == KIND_CIRCLE)) &&
                   ((in_data.b_kind == KIND_BOX) || (in_data.b_kind == KIND_CIRCLE));
        pair_sel = {in_data.a_kind[0], in_data.b_kind[0]};
        mode_next = PAIR_NONE;
        if (kind_ok && pair_enable[pair_sel])
        begin
            unique case (pair_sel)
                EN_BOX_BOX:       mode_next = PAIR_BB;
                EN_BOX_CIRCLE:    mode_next = PAIR_BC;
                EN_CIRCLE_BOX:    mode_next = PAIR_CB;
                EN_CIRCLE_CIRCLE: mode_next = PAIR_CC;
            endcase
        end
    end

    assign in_ready = !valid_reg || push_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_data;
            mode_reg <= mode_next;
        end
    end

    // circle first; the other shape is a box, or a zero sized box at the centre
    always_comb
    begin
        swap  = (mode_reg == PAIR_BC);
        round = (mode_reg == PAIR_CC);
        c_x   = swap ? item_reg.b_x : item_reg.a_x;
        c_y   = swap ? item_reg.b_y : item_reg.a_y;
        c_r   = swap ? item_reg.b_size_one : item_reg.a_size_one;
        o_x   = swap ? item_reg.a_x : item_reg.b_x;
        o_y   = swap ? item_reg.a_y : item_reg.b_y;
        o_r   = swap ? item_reg.a_size_one : item_reg.b_size_one;
        o_w   = round ? '0 : o_r;
        o_h   = round ? '0 : (swap ? item_reg.a_size_two : item_reg.b_size_two);

        ax_lo = ext_coord_t'(item_reg.a_x);
        ay_lo = ext_coord_t'(item_reg.a_y);
        bx_lo = ext_coord_t'(item_reg.b_x);
        by_lo = ext_coord_t'(item_reg.b_y);
        ax_hi = ax_lo + $signed({2'b00, item_reg.a_size_one});
        ay_hi = ay_lo + $signed({2'b00, item_reg.a_size_two});
        bx_hi = bx_lo + $signed({2'b00, item_reg.b_size_one});
        by_hi = by_lo + $signed({2'b00, item_reg.b_size_two});

        push_data.box_hit = (ax_lo < bx_hi) && (ax_hi > bx_lo) &&
                            (ay_lo < by_hi) && (ay_hi > by_lo);
        push_data.dist_x  = axis_gap(c_x, o_x, o_w);
        push_data.dist_y  = axis_gap(c_y, o_y, o_h);
        push_data.rad     = RAD_BITS'(c_r) + (round ? RAD_BITS'(o_r) : '0);

        unique case (mode_reg)
            PAIR_NONE: push_data.kind = JOB_SKIP;
            PAIR_BB:   push_data.kind = JOB_BOX;
            PAIR_BC,
            PAIR_CB,
            PAIR_CC:   push_data.kind = JOB_ROUND;
            default:   push_data.kind = JOB_SKIP;
        endcase
    end

    assign push_valid = valid_reg;

    `SPO_ASSERT_NEXT(a_front_hold, valid_reg && !push_ready, valid_reg && $stable(mode_reg))

endmodule
`default_nettype wire

// ===== rtl/core/spo_queue.sv =====
`default_nettype none
`include "shape_pair_overlap_test_macros.svh"
module spo_queue
    import spo_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_data
);

    job_t                 slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_next;
    logic [QPTR_BITS:0]   count_reg;
    logic [QPTR_BITS:0]   count_next;
    logic                 push_fire;
    logic                 pop_fire;

    assign push_ready = (count_reg != (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_fire)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_fire && !pop_fire)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_fire && !push_fire)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    `SPO_ASSERT_SAME(a_queue_bound, 1'b1, count_reg <= (QPTR_BITS+1)'(QUEUE_DEPTH))
    `SPO_ASSERT_NEXT(a_queue_grow, push_fire && !pop_fire, count_reg == $past(count_reg) + 1)

endmodule
`default_nettype wire

// ===== rtl/core/spo_back.sv =====
`default_nettype none
`include "shape_pair_overlap_test_macros.svh"
module spo_back
    import spo_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      pop_valid,
    output logic      pop_ready,
    input  job_t      pop_data,
    output logic      out_valid,
    input  logic      out_ready,
    output pair_out_t out_data
);

    logic                 s1_valid_reg;
    job_kind_t            s1_kind_reg;
    logic                 s1_box_hit_reg;
    logic [SQ_BITS-1:0]   sq_x_reg;
    logic [SQ_BITS-1:0]   sq_y_reg;
    logic [RSQ_BITS-1:0]  sq_r_reg;
    logic                 out_valid_reg;
    pair_out_t            out_data_reg;
    pair_out_t            out_data_next;
    logic                 out_free;
    logic                 s1_move;
    logic [DIST_BITS-1:0] dist_sum;

    assign out_free  = !out_valid_reg || out_ready;
    assign s1_move   = s1_valid_reg && out_free;
    assign pop_ready = !s1_valid_reg || out_free;

    // squaring stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (pop_ready)
        begin
            s1_valid_reg <= pop_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_valid && pop_ready)
        begin
            s1_kind_reg    <= pop_data.kind;
            s1_box_hit_reg <= pop_data.box_hit;
            sq_x_reg       <= SQ_BITS'(pop_data.dist_x) * SQ_BITS'(pop_data.dist_x);
            sq_y_reg       <= SQ_BITS'(pop_data.dist_y) * SQ_BITS'(pop_data.dist_y);
            sq_r_reg       <= RSQ_BITS'(pop_data.rad) * RSQ_BITS'(pop_data.rad);
        end
    end

    // sum and compare, touching counts as a hit
    always_comb
    begin
        dist_sum = DIST_BITS'(sq_x_reg) + DIST_BITS'(sq_y_reg);
        unique case (s1_kind_reg)
            JOB_SKIP:
            begin
                out_data_next.hit    = 1'b0;
                out_data_next.status = STATUS_UNSUPPORTED;
            end
            JOB_BOX:
            begin
                out_data_next.hit    = s1_box_hit_reg;
                out_data_next.status = STATUS_TESTED;
            end
            JOB_ROUND:
            begin
                out_data_next.hit    = (dist_sum <= DIST_BITS'(sq_r_reg));
                out_data_next.status = STATUS_TESTED;
            end
            default:
            begin
                out_data_next.hit    = 1'b0;
                out_data_next.status = STATUS_UNSUPPORTED;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `SPO_ASSERT_SAME(a_skip_no_hit,
                     out_valid_reg && (out_data_reg.status == STATUS_UNSUPPORTED),
                     !out_data_reg.hit)
    `SPO_ASSERT_NEXT(a_stage_hold, s1_valid_reg && out_valid_reg && !out_ready, s1_valid_reg)

endmodule
`default_nettype wire

// ===== bench/shape_pair_overlap_test_test.sv =====
`timescale 1ns / 1ps

module shape_pair_overlap_test_test;
    import spo_pkg::*;

    localparam logic [1:0] KIND_OTHER = 2'd2;
    localparam logic [1:0] KIND_SPARE = 2'd3;

    localparam int COORD_MIN    = -(2 ** (COORD_BITS - 1));
    localparam int COORD_MAX    = 2 ** (COORD_BITS - 1) - 1;
    localparam int SIZE_MAX     = 2 ** SIZE_BITS - 1;
    localparam int LATENCY      = 4;
    localparam int SETTLE_GAP   = LATENCY + 4;
    localparam int HOLD_CYCLES  = 200;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_REPORTS  = 10;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    pair_in_t                in_data;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    pair_out_t               out_data;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [PAIR_EN_BITS-1:0] cfg_data;

    // expected verdicts in order of input transfer
    pair_out_t               verdicts_due[$];
    logic [PAIR_EN_BITS-1:0] enable_mask;

    bit tx_idle;
    bit rx_idle;
    int hold_asked;
    int hold_served;
    int hold_left;
    int ready_wait;
    int rx_stall;

    int cycle_count;
    int pairs_sent;
    int verdicts_checked;
    int hits_seen;
    int unsupported_seen;
    int mask_writes;
    int input_stalls;
    int faults;

    shape_pair_overlap_test dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("run stopped after %0d cycles, %0d verdicts outstanding",
                     cycle_count, verdicts_due.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic round_meets_box(longint cx, longint cy, longint r,
                                             longint bx, longint by,
                                             longint bw, longint bh);
        longint px;
        longint py;
        px = (cx < bx) ? bx : cx;
        px = (px > bx + bw) ? bx + bw : px;
        py = (cy < by) ? by : cy;
        py = (py > by + bh) ? by + bh : py;
        // touching counts
        return (px - cx) * (px - cx) + (py - cy) * (py - cy) <= r * r;
    endfunction

    function automatic pair_out_t predict_verdict(pair_in_t p,
                                                  logic [PAIR_EN_BITS-1:0] enables);
        pair_out_t v;
        longint ax;
        longint ay;
        longint aw;
        longint ah;
        longint bx;
        longint by;
        longint bw;
        longint bh;
        ax = $signed(p.a_x);
        ay = $signed(p.a_y);
        aw = longint'(p.a_size_one);
        ah = longint'(p.a_size_two);
        bx = $signed(p.b_x);
        by = $signed(p.b_y);
        bw = longint'(p.b_size_one);
        bh = longint'(p.b_size_two);
        v.hit    = 1'b0;
        v.status = STATUS_UNSUPPORTED;
        // enable bit index is {a is circle, b is circle}
        if (p.a_kind <= KIND_CIRCLE && p.b_kind <= KIND_CIRCLE
            && enables[{p.a_kind[0], p.b_kind[0]}])
        begin
            v.status = STATUS_TESTED;
            if (p.a_kind == KIND_BOX && p.b_kind == KIND_BOX)
                v.hit = ax < bx + bw && ax + aw > bx && ay < by + bh && ay + ah > by;
            else if (p.a_kind == KIND_CIRCLE && p.b_kind == KIND_CIRCLE)
                v.hit = (ax - bx) * (ax - bx) + (ay - by) * (ay - by)
                        <= (aw + bw) * (aw + bw);
            else if (p.a_kind == KIND_CIRCLE)
                v.hit = round_meets_box(ax, ay, aw, bx, by, bw, bh);
            else
                v.hit = round_meets_box(bx, by, bw, ax, ay, aw, ah);
        end
        return v;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic pair_in_t make_pair(logic [1:0] ak, int ax, int ay, int as1, int as2,
                                           logic [1:0] bk, int bx, int by, int bs1, int bs2);
        pair_in_t p;
        p.a_kind     = ak;
        p.a_x        = coord_t'(ax);
        p.a_y        = coord_t'(ay);
        p.a_size_one = dim_t'(as1);
        p.a_size_two = dim_t'(as2);
        p.b_kind     = bk;
        p.b_x        = coord_t'(bx);
        p.b_y        = coord_t'(by);
        p.b_size_one = dim_t'(bs1);
        p.b_size_two = dim_t'(bs2);
        return p;
    endfunction

    function automatic logic [1:0] random_kind();
        int r;
        r = $urandom_range(0, 19);
        if (r < 9)
            return KIND_BOX;
        else if (r < 18)
            return KIND_CIRCLE;
        else if (r == 18)
            return KIND_OTHER;
        return KIND_SPARE;
    endfunction

    function automatic int edge_coord();
        case ($urandom_range(0, 4))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2: return 0;
            3: return -1;
            default: return 1;
        endcase
    endfunction

    function automatic int edge_size();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return SIZE_MAX;
            default: return 1;
        endcase
    endfunction

    function automatic int jitter(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // mostly nearby shapes of a common scale so hits and misses both occur,
    // some raw bit patterns and some pairs at the range limits
    function automatic pair_in_t random_pair();
        pair_in_t p;
        int pick;
        int span;
        int base_x;
        int base_y;
        pick = $urandom_range(0, 9);
        if (pick < 2)
        begin
            p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            if (pick == 0)
            begin
                p.a_kind = random_kind();
                p.b_kind = random_kind();
            end
        end
        else if (pick == 2)
            p = make_pair(random_kind(), edge_coord(), edge_coord(), edge_size(), edge_size(),
                          random_kind(), edge_coord(), edge_coord(), edge_size(), edge_size());
        else
        begin
            span   = 1 << $urandom_range(2, 20);
            base_x = int'($urandom_range(0, 1 << 23)) - (1 << 22);
            base_y = int'($urandom_range(0, 1 << 23)) - (1 << 22);
            p = make_pair(random_kind(), base_x + jitter(span), base_y + jitter(span),
                          $urandom_range(0, span), $urandom_range(0, span),
                          random_kind(), base_x + jitter(span), base_y + jitter(span),
                          $urandom_range(0, span), $urandom_range(0, span));
        end
        return p;
    endfunction

    // ---------------------------------------------------------------- driving

    task automatic send_pair(input pair_in_t p);
        int gap;
        gap = tx_idle ? $urandom_range(0, 14) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= p;
        @(posedge clk);
        while (!in_ready)
        begin
            input_stalls++;
            @(posedge clk);
        end
        verdicts_due.push_back(predict_verdict(p, enable_mask));
        pairs_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_GAP) @(posedge clk);
    endtask

    task automatic write_enables(input logic [PAIR_EN_BITS-1:0] mask);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= mask;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid   <= 1'b0;
        enable_mask  = mask;
        mask_writes++;
    endtask

    // ---------------------------------------------------------------- receiving

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready   <= 1'b0;
            ready_wait  <= 0;
            hold_left   <= 0;
            hold_served <= 0;
        end
        else if (hold_served != hold_asked)
        begin
            hold_served <= hold_asked;
            hold_left   <= HOLD_CYCLES;
            out_ready   <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (ready_wait > 0)
        begin
            ready_wait <= ready_wait - 1;
            out_ready  <= (ready_wait == 1);
        end
        else if (out_valid && out_ready)
        begin
            rx_stall    = rx_idle ? $urandom_range(0, 14) : 0;
            ready_wait <= rx_stall;
            out_ready  <= (rx_stall == 0);
        end
        else
            out_ready <= 1'b1;
    end

    task automatic note_fault(input string msg);
        faults++;
        if (faults <= MAX_REPORTS)
            $display("[%0t] %s", $realtime, msg);
    endtask

    always @(posedge clk)
    begin
        pair_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (verdicts_due.size() == 0)
                note_fault($sformatf("verdict with nothing pending: hit %0b status %0b",
                                     out_data.hit, out_data.status));
            else
            begin
                want = verdicts_due.pop_front();
                if (out_data.hit !== want.hit || out_data.status !== want.status)
                    note_fault($sformatf("verdict %0d: expected hit/status %0b/%0b, got %0b/%0b",
                                         verdicts_checked, want.hit, want.status,
                                         out_data.hit, out_data.status));
                hits_seen        += want.hit;
                unsupported_seen += (want.status == STATUS_UNSUPPORTED);
                verdicts_checked++;
            end
        end
    end

    // ---------------------------------------------------------------- tests

    // runs on the reset value of the enable mask
    task automatic test_directed();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        // box against box, strict on both axes
        send_pair(make_pair(KIND_BOX, 0, 0, 256, 256, KIND_BOX, 128, 128, 256, 256));
        send_pair(make_pair(KIND_BOX, 0, 0, 256, 256, KIND_BOX, 256, 0, 256, 256));
        send_pair(make_pair(KIND_BOX, 0, 0, 256, 256, KIND_BOX, 0, -256, 256, 256));
        // zero width or height never overlaps
        send_pair(make_pair(KIND_BOX, 0, 0, 0, 256, KIND_BOX, 0, 0, 256, 256));
        send_pair(make_pair(KIND_BOX, 10, 10, 256, 256, KIND_BOX, 0, 0, 256, 0));
        // circles just touching and just apart
        send_pair(make_pair(KIND_CIRCLE, 0, 0, 300, 0, KIND_CIRCLE, 600, 0, 300, 0));
        send_pair(make_pair(KIND_CIRCLE, 0, 0, 300, 0, KIND_CIRCLE, 601, 0, 300, 0));
        // zero radius circles are points
        send_pair(make_pair(KIND_CIRCLE, -5, 7, 0, 99, KIND_CIRCLE, -5, 7, 0, 3));
        send_pair(make_pair(KIND_CIRCLE, -5, 7, 0, 0, KIND_CIRCLE, -5, 8, 0, 0));
        // circle touching a box corner, both orders
        send_pair(make_pair(KIND_CIRCLE, -300, -400, 500, 0, KIND_BOX, 0, 0, 256, 256));
        send_pair(make_pair(KIND_BOX, 0, 0, 256, 256, KIND_CIRCLE, 556, 656, 500, 0));
        send_pair(make_pair(KIND_BOX, 0, 0, 256, 256, KIND_CIRCLE, 557, 656, 500, 0));
        // centre inside the box
        send_pair(make_pair(KIND_BOX, -1000, -1000, 4000, 4000, KIND_CIRCLE, 5, 5, 0, 0));
        // other kinds, including the unused code
        send_pair(make_pair(KIND_OTHER, 0, 0, 256, 256, KIND_BOX, 0, 0, 256, 256));
        send_pair(make_pair(KIND_CIRCLE, 0, 0, 256, 256, KIND_SPARE, 0, 0, 256, 256));
        send_pair(make_pair(KIND_SPARE, 0, 0, 1, 1, KIND_OTHER, 0, 0, 1, 1));
        // range limits
        send_pair(make_pair(KIND_BOX, COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX,
                            KIND_BOX, COORD_MAX, COORD_MAX, SIZE_MAX, SIZE_MAX));
        send_pair(make_pair(KIND_BOX, COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX,
                            KIND_BOX, -1, -1, SIZE_MAX, SIZE_MAX));
        send_pair(make_pair(KIND_BOX, COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX,
                            KIND_BOX, -2, -2, SIZE_MAX, SIZE_MAX));
        send_pair(make_pair(KIND_CIRCLE, COORD_MAX, COORD_MAX, SIZE_MAX, 0,
                            KIND_CIRCLE, COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX));
        send_pair(make_pair(KIND_CIRCLE, COORD_MIN, 0, SIZE_MAX, 0,
                            KIND_CIRCLE, COORD_MAX, 0, SIZE_MAX, 0));
        send_pair(make_pair(KIND_CIRCLE, 0, 0, SIZE_MAX, SIZE_MAX,
                            KIND_BOX, COORD_MIN, COORD_MIN, 0, 0));
        // box reaching past the coordinate range
        send_pair(make_pair(KIND_CIRCLE, COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX,
                            KIND_BOX, COORD_MAX, COORD_MAX, SIZE_MAX, SIZE_MAX));
        send_pair(make_pair(KIND_BOX, COORD_MAX, COORD_MAX, SIZE_MAX, SIZE_MAX,
                            KIND_CIRCLE, COORD_MAX, COORD_MAX, 0, 0));
        send_pair(make_pair(KIND_CIRCLE, -1, -1, 1, 1, KIND_CIRCLE, 0, 0, 0, 0));
        drain();
    endtask

    task automatic test_pair_enables();
        logic [PAIR_EN_BITS-1:0] masks[9];
        masks = '{4'h0, 4'h1, 4'h2, 4'h4, 4'h8, 4'h6, 4'h9,
                  PAIR_EN_BITS'($urandom_range(0, 15)), 4'hF};
        for (int m = 0; m < 9; m++)
        begin
            tx_idle = m[0];
            rx_idle = m[1];
            write_enables(masks[m]);
            for (int i = 0; i < 20; i++)
                send_pair(random_pair());
        end
        drain();
    endtask

    task automatic test_random_stream();
        for (int seg = 0; seg < 6; seg++)
        begin
            // alternate idling on each side, with two stretches of none at all
            tx_idle = (seg == 0 || seg == 2 || seg == 4);
            rx_idle = (seg == 0 || seg == 3 || seg == 4);
            write_enables((seg == 3) ? PAIR_EN_BITS'($urandom_range(1, 14)) : 4'hF);
            for (int i = 0; i < 150; i++)
                send_pair(random_pair());
        end
        drain();
    endtask

    // receiver holds off while the sender keeps offering, so in_ready must drop
    task automatic test_backpressure();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        hold_asked++;
        for (int i = 0; i < 40; i++)
            send_pair(random_pair());
        rx_idle = 1'b1;
        for (int i = 0; i < 20; i++)
            send_pair(random_pair());
        drain();
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        in_data     <= '0;
        cfg_valid   <= 1'b0;
        cfg_data    <= '0;
        enable_mask  = PAIR_EN_RESET;
        hold_asked   = 0;
        tx_idle      = 1'b0;
        rx_idle      = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_pair_enables();
        test_random_stream();
        test_backpressure();

        if (verdicts_due.size() != 0)
            note_fault($sformatf("%0d verdicts never arrived", verdicts_due.size()));
        $display("%0d shape pairs in %0d cycles, %0d verdicts checked: %0d hits, %0d unsupported",
                 pairs_sent, cycle_count, verdicts_checked, hits_seen, unsupported_seen);
        $display("%0d enable mask writes, %0d cycles with input held off, %0d faults",
                 mask_writes, input_stalls, faults);
        if (faults == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/spo_pkg.sv
rtl/core/spo_front.sv
rtl/core/spo_queue.sv
rtl/core/spo_back.sv
rtl/core/shape_pair_overlap_test.sv
bench/shape_pair_overlap_test_test.sv
